FILE: rtl/set_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package set_pkg;

   // Geometry of the raster line and of the trailing luma store.
   localparam int LINE_WIDTH = 1024;
   localparam int WIN_DEPTH  = 2 * LINE_WIDTH + 2;
   localparam int PTR_W      = $clog2(LINE_WIDTH);
   localparam int FILL_W     = $clog2(WIN_DEPTH + 1);

   // Field widths.
   localparam int PIXEL_W  = 24;
   localparam int LUMA_W   = 8;
   localparam int THRESH_W = 12;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register map: word index taken from the upper address bit.
   localparam logic CSR_IDX_EDGE_THRESHOLD = 1'b0;

   localparam logic [LUMA_W-1:0]  BLACK_LUMA = 8'd16;
   localparam logic [PIXEL_W-1:0] EDGE_VALUE = 24'hffffff;
   localparam logic [PIXEL_W-1:0] FLAT_VALUE = 24'h000000;

   typedef logic [LUMA_W-1:0] luma_type;

   // Trailing 3x3 window: tap[i][j] is the luma i*LINE_WIDTH+j pixels back.
   typedef struct packed {
      luma_type [2:0][2:0] tap;
   } window_type;

   // Integer luma of an RGB pixel, always within 16..235.
   function automatic luma_type rgb_to_luma(input logic [PIXEL_W-1:0] rgb);
      logic [15:0] sum;
      sum = 16'(rgb[23:16]) * 16'd66 + 16'(rgb[15:8]) * 16'd129
          + 16'(rgb[7:0]) * 16'd25 + 16'd128;
      return sum[15:8] + BLACK_LUMA;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/set_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module set_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/set_gradient.sv
`timescale 1ns / 1ps
`default_nettype none

module set_gradient (
   input  wire set_pkg::window_type                  window,
   input  wire logic [set_pkg::THRESH_W-1:0]         threshold,
   output logic                                      is_edge
);
   import set_pkg::*;

   logic [9:0]  gx_pos, gx_neg, gy_pos, gy_neg;
   logic [9:0]  gx_abs, gy_abs;
   logic [10:0] magnitude;

   // Weighted 1-2-1 sums of the opposite window rows and columns.
   always_comb begin
      gx_pos = 10'(window.tap[2][0]) + {1'b0, window.tap[2][1], 1'b0}
             + 10'(window.tap[2][2]);
      gx_neg = 10'(window.tap[0][0]) + {1'b0, window.tap[0][1], 1'b0}
             + 10'(window.tap[0][2]);
      gy_pos = 10'(window.tap[0][2]) + {1'b0, window.tap[1][2], 1'b0}
             + 10'(window.tap[2][2]);
      gy_neg = 10'(window.tap[0][0]) + {1'b0, window.tap[1][0], 1'b0}
             + 10'(window.tap[2][0]);
   end

   // Absolute differences, then the L1 magnitude against the threshold.
   always_comb begin
      gx_abs    = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
      gy_abs    = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
      magnitude = 11'(gx_abs) + 11'(gy_abs);
      is_edge   = THRESH_W'(magnitude) > threshold;
   end

endmodule

`default_nettype wire

FILE: rtl/sobel_edge_threshold_stream.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Content
// req_*     in         tdata: pixel_rgb[23:0]; tuser: start_of_frame
// rsp_*     out        tdata: edge_pixel[23:0]
// csr_*     in         APB register port: edge_threshold at byte address 0
//
// One pixel per cycle unless the result side stalls; a taken pixel passes
// the input window register, then the result register. The line RAM has a
// registered read, so it is addressed ahead by the next line position.
// Reset clears the control state at once; a fill count marks which window
// taps hold pixels of the current frame, so no clearing pass runs.
// A stalled result holds; the window register keeps taking pixels until both
// stages are full.

module sobel_edge_threshold_stream (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // pixel_rgb[23:0]
   input  wire logic [set_pkg::PIXEL_W-1:0]       req_tdata,
   // start_of_frame
   input  wire logic                              req_tuser,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // edge_pixel[23:0]
   output logic [set_pkg::PIXEL_W-1:0]            rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [set_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [set_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [set_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);
   import set_pkg::*;

   logic [THRESH_W-1:0] threshold_ff;
   logic                csr_write;

   logic                req_beat;
   logic                s1_free, out_free;
   luma_type            cur_luma;
   logic [FILL_W-1:0]   eff_fill, fill_ff, fill_in;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic [15:0]         line_rd, line_wr;
   luma_type            x1_ff, x2_ff, a1_ff, a2_ff, b1_ff, b2_ff;
   luma_type [2:0][2:0] raw_taps;
   window_type          window_in, window_ff;
   logic                s1_valid_ff;
   logic                is_edge;
   logic [PIXEL_W-1:0]  rsp_tdata_ff;
   logic                rsp_valid_ff;

   // Register port: always ready, threshold in the low bits of word zero.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_IDX_EDGE_THRESHOLD);

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_EDGE_THRESHOLD) begin
         csr_prdata = CSR_DATA_W'(threshold_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_write) begin
         threshold_ff <= csr_pwdata[THRESH_W-1:0];
      end
   end

   // Two-stage flow control: window register, then result register.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_free    = !s1_valid_ff || out_free;
   assign req_tready = s1_free;
   assign req_beat   = req_tvalid && req_tready;

   assign cur_luma = rgb_to_luma(req_tdata);

   // Fill count of pixels seen since the frame start, saturating at the depth.
   always_comb begin
      eff_fill = req_tuser ? '0 : fill_ff;
      fill_in  = fill_ff;
      if (req_beat) begin
         fill_in = (eff_fill == FILL_W'(WIN_DEPTH)) ? eff_fill : eff_fill + 1'b1;
      end
   end

   // Line position; the RAM is read at the next position so its data is
   // ready when the next pixel arrives.
   always_comb begin
      ptr_in = ptr_ff;
      if (req_beat) begin
         ptr_in = (ptr_ff == PTR_W'(LINE_WIDTH - 1)) ? '0 : ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         ptr_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         ptr_ff  <= ptr_in;
      end
   end

   // Each RAM word holds the luma one line back (low) and two lines back (high).
   assign line_wr = {line_rd[7:0], cur_luma};

   set_ram #(
      .WIDTH (16),
      .DEPTH (LINE_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (req_beat),
      .wr_addr (ptr_ff),
      .wr_data (line_wr),
      .rd_addr (ptr_in),
      .rd_data (line_rd)
   );

   // Short delay taps beside each line.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         x1_ff <= cur_luma;
         x2_ff <= x1_ff;
         a1_ff <= line_rd[7:0];
         a2_ff <= a1_ff;
         b1_ff <= line_rd[15:8];
         b2_ff <= b1_ff;
      end
   end

   // Taps older than the frame start read as black.
   always_comb begin
      raw_taps[0][0] = cur_luma;
      raw_taps[0][1] = x1_ff;
      raw_taps[0][2] = x2_ff;
      raw_taps[1][0] = line_rd[7:0];
      raw_taps[1][1] = a1_ff;
      raw_taps[1][2] = a2_ff;
      raw_taps[2][0] = line_rd[15:8];
      raw_taps[2][1] = b1_ff;
      raw_taps[2][2] = b2_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            window_in.tap[i][j] = (FILL_W'(i * LINE_WIDTH + j) <= eff_fill)
                                  ? raw_taps[i][j] : BLACK_LUMA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         window_ff <= window_in;
      end
   end

   set_gradient u_gradient (
      .window    (window_ff),
      .threshold (threshold_ff),
      .is_edge   (is_edge)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_tdata_ff <= is_edge ? EDGE_VALUE : FLAT_VALUE;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WIN_DEPTH))
      else $error("fill count beyond window depth");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_W'(LINE_WIDTH - 1))
      else $error("line position out of range");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_tuser) |=> (fill_ff == FILL_W'(1)))
      else $error("frame start did not restart the fill count");

   a_result_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_tdata_ff == EDGE_VALUE || rsp_tdata_ff == FLAT_VALUE))
      else $error("result is neither edge nor flat");

   a_window_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |=> s1_valid_ff)
      else $error("window beat dropped while result stalled");

endmodule

`default_nettype wire

FILE: test/sobel_edge_threshold_stream_tb.sv
`timescale 1ns / 1ps

module sobel_edge_threshold_stream_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_CHUNK = 140;
   localparam logic [set_pkg::CSR_ADDR_W-1:0] THRESHOLD_ADDR =
      {set_pkg::CSR_IDX_EDGE_THRESHOLD, 2'b00};

   logic clock;
   logic reset = 1'b1;

   logic [set_pkg::PIXEL_W-1:0]    req_tdata = '0;   // pixel_rgb[23:0]
   logic                           req_tuser = 1'b0; // start_of_frame
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [set_pkg::PIXEL_W-1:0]    rsp_tdata;        // edge_pixel[23:0]
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [set_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [set_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [set_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // Predicted state: the trailing luma history and the threshold in force.
   set_pkg::luma_type              luma_history [set_pkg::WIN_DEPTH];
   int unsigned                    history_pos;
   logic [set_pkg::THRESH_W-1:0]   threshold_setting;
   logic [set_pkg::PIXEL_W-1:0]    expected_edges [$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int sender_idle_pct = 27;
   int receiver_idle_pct = 74;
   int rsp_hold_left = 0;
   int frames_started = 0;
   int frame_pixels_left = 0;
   logic [set_pkg::PIXEL_W-1:0] last_rgb = '0;

   sobel_edge_threshold_stream DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Free-running clock, 8 ns period.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sobel_edge_threshold_stream verification failed");
         $finish;
      end
   end

   // Result side: random stalls, or a held-off stretch when one is requested.
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Compare every accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_edges.size() == 0) begin
            $error("edge_pixel: no result expected, got %h", rsp_tdata);
            mismatch_count++;
         end else begin
            if (rsp_tdata !== expected_edges[0]) begin
               $error("edge_pixel: expected %h, got %h", expected_edges[0], rsp_tdata);
               mismatch_count++;
            end
            void'(expected_edges.pop_front());
         end
      end
   end

   // A frame start refills the history with black luma.
   function automatic void clear_history();
      for (int k = 0; k < set_pkg::WIN_DEPTH; k++) begin
         luma_history[k] = set_pkg::BLACK_LUMA;
      end
      history_pos = 0;
   endfunction

   function automatic set_pkg::luma_type pixel_luma(input logic [set_pkg::PIXEL_W-1:0] rgb);
      int unsigned weighted;
      weighted = 66 * rgb[23:16] + 129 * rgb[15:8] + 25 * rgb[7:0] + 128;
      return 8'((weighted >> 8) + 16);
   endfunction

   // Sobel magnitude over the trailing window whose bottom-right corner is
   // the current pixel; the window simply wraps across row ends.
   function automatic logic [set_pkg::PIXEL_W-1:0] predict_edge_pixel(
         input logic [set_pkg::PIXEL_W-1:0] rgb, input logic frame_start);
      set_pkg::luma_type cur;
      set_pkg::luma_type tap;
      int gx;
      int gy;
      int mag;
      int unsigned tap_dist;
      if (frame_start) clear_history();
      cur = pixel_luma(rgb);
      gx = 0;
      gy = 0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            tap_dist = i * set_pkg::LINE_WIDTH + j;
            if (tap_dist == 0) tap = cur;
            else tap = luma_history[(history_pos + set_pkg::WIN_DEPTH - tap_dist)
                                    % set_pkg::WIN_DEPTH];
            // Row kernel weights by i, column kernel by j; the middle tap counts twice.
            gx += int'(tap) * (i - 1) * ((j == 1) ? 2 : 1);
            gy += int'(tap) * (j - 1) * ((i == 1) ? 2 : 1);
         end
      end
      mag = ((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy);
      luma_history[history_pos] = cur;
      history_pos = (history_pos + 1) % set_pkg::WIN_DEPTH;
      return (mag > int'(threshold_setting)) ? set_pkg::EDGE_VALUE : set_pkg::FLAT_VALUE;
   endfunction

   // Offer one pixel beat; valid stays high between back-to-back beats.
   task automatic send_pixel(input logic [set_pkg::PIXEL_W-1:0] rgb, input logic frame_start);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= rgb;
      req_tuser <= frame_start;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_edges.push_back(predict_edge_pixel(rgb, frame_start));
      last_rgb = rgb;
   endtask

   // Stop offering and wait until every predicted result has been seen.
   task automatic wait_edges_drained();
      req_tvalid <= 1'b0;
      while (expected_edges.size() != 0) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle. Only the low 12 bits count.
   task automatic set_threshold(input logic [set_pkg::CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= THRESHOLD_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      threshold_setting = value[set_pkg::THRESH_W-1:0];
   endtask

   // Straight after reset: threshold 0 and an all-black history, no frame start.
   task automatic test_reset_state();
      send_pixel(24'h000000, 1'b0);
      send_pixel(24'hffffff, 1'b0);
      send_pixel(24'hff0000, 1'b0);
      send_pixel(24'h00ff00, 1'b0);
      send_pixel(24'h0000ff, 1'b0);
   endtask

   // Threshold extremes, and the exact boundary of a lone white pixel after a
   // frame start, whose gradient magnitude is 438.
   task automatic test_threshold_limits();
      wait_edges_drained();
      set_threshold(32'hfffff_fff);
      send_pixel(24'hffffff, 1'b1);
      repeat (3) send_pixel(24'($urandom), 1'b0);
      wait_edges_drained();
      set_threshold(32'h0000_0000);
      send_pixel(24'h000000, 1'b1);
      send_pixel(24'h000000, 1'b0);
      wait_edges_drained();
      set_threshold(32'h5a5a_51b6);
      send_pixel(24'hffffff, 1'b1);
      wait_edges_drained();
      set_threshold(32'd437);
      send_pixel(24'hffffff, 1'b1);
   endtask

   // A frame start in mid-stream must forget the bright pixels before it.
   task automatic test_frame_start();
      wait_edges_drained();
      set_threshold(32'd100);
      repeat (4) send_pixel(24'($urandom) | 24'hc0c0c0, 1'b0);
      send_pixel(24'h000000, 1'b1);
      send_pixel(24'hffffff, 1'b0);
   endtask

   // Long hold-off on the result side while pixels keep coming, so the block
   // stalls its input; then the sender waits for all results mid-frame.
   task automatic test_backpressure();
      wait_edges_drained();
      set_threshold(32'd300);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      rsp_hold_left <= 64;
      send_pixel(24'($urandom), 1'b1);
      repeat (39) send_pixel(24'($urandom), 1'b0);
      wait_edges_drained();
      repeat (10) send_pixel(24'($urandom), 1'b0);
   endtask

   // Random frames of random content. The run's first frame goes well past one
   // row length; some others pass one row length so the window wraps a row end.
   task automatic test_random_frames(input int sender_pct, input int receiver_pct,
                                     input int chunks);
      logic [set_pkg::PIXEL_W-1:0] rgb;
      logic frame_start;
      sender_idle_pct = sender_pct;
      receiver_idle_pct = receiver_pct;
      for (int c = 0; c < chunks; c++) begin
         wait_edges_drained();
         case ($urandom_range(0, 4))
            0: set_threshold({20'($urandom), 12'h000});
            1: set_threshold({20'($urandom), 12'hfff});
            2: set_threshold($urandom);
            3: set_threshold(32'($urandom_range(0, 500)));
            default: set_threshold(32'($urandom_range(400, 1752)));
         endcase
         for (int n = 0; n < RANDOM_CHUNK; n++) begin
            frame_start = (frame_pixels_left == 0);
            if (frame_start) begin
               if (frames_started == 0) frame_pixels_left = set_pkg::LINE_WIDTH + 200;
               else if ($urandom_range(0, 9) < 7) frame_pixels_left = $urandom_range(1, 40);
               else if ($urandom_range(0, 2) != 0)
                  frame_pixels_left = $urandom_range(set_pkg::LINE_WIDTH + 1,
                                                     set_pkg::LINE_WIDTH + 80);
               else frame_pixels_left = 1;
               frames_started++;
            end
            frame_pixels_left--;
            case ($urandom_range(0, 9))
               0, 1, 2: rgb = 24'($urandom);
               3, 4:    rgb = 24'h000000;
               5, 6:    rgb = 24'hffffff;
               7, 8:    rgb = last_rgb;
               default: rgb = 24'($urandom_range(0, 255)) << (8 * $urandom_range(0, 2));
            endcase
            send_pixel(rgb, frame_start);
         end
      end
   endtask

   // Test sequence.
   initial begin
      clear_history();
      threshold_setting = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_threshold_limits();
      test_frame_start();
      test_random_frames(27, 74, 4);
      test_random_frames(74, 27, 4);
      test_random_frames(0, 0, 4);
      test_backpressure();
      wait_edges_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_edges.size() == 0) begin
         $display("sobel_edge_threshold_stream verification clean");
      end else begin
         $display("sobel_edge_threshold_stream verification failed");
      end
      $finish;
   end

endmodule
